// ===== rtl/bjc_pkg.sv =====
// ----------------------------------------------------------------------------
// bjc_pkg: shared types and helpers of the branch/jump/call unit
// Instruction kinds, condition codes, timing codes, item structs.
// ----------------------------------------------------------------------------
`default_nettype none

package bjc_pkg;

	// instruction kind, as carried on the input tuser
	typedef enum logic [3:0] {
		KIND_NOP    = 4'd0,
		KIND_DJNZ   = 4'd1,
		KIND_JR     = 4'd2,
		KIND_JRNZ   = 4'd3,
		KIND_JRZ    = 4'd4,
		KIND_JRNC   = 4'd5,
		KIND_JRC    = 4'd6,
		KIND_JP     = 4'd7,
		KIND_JPCC   = 4'd8,
		KIND_JPHL   = 4'd9,
		KIND_CALL   = 4'd10,
		KIND_CALLCC = 4'd11,
		KIND_RET    = 4'd12,
		KIND_RETCC  = 4'd13,
		KIND_RST    = 4'd14
	} kind_t;

	// condition field, opcode bits 5:3
	typedef enum logic [2:0] {
		COND_NZ = 3'd0,
		COND_Z  = 3'd1,
		COND_NC = 3'd2,
		COND_C  = 3'd3,
		COND_PO = 3'd4,
		COND_PE = 3'd5,
		COND_P  = 3'd6,
		COND_M  = 3'd7
	} cond_t;

	// short cycle counts of a branch not taken
	typedef enum logic [2:0] {
		TIM_DEFAULT     = 3'd0,
		TIM_DJNZ_FALL   = 3'd1,
		TIM_JRCC_SKIP   = 3'd2,
		TIM_RETCC_SKIP  = 3'd3,
		TIM_CALLCC_SKIP = 3'd4
	} timing_t;

	localparam logic [7:0] RST_VEC_MASK = 8'h38;
	localparam int         IN_DATA_W    = 104;
	localparam int         OUT_DATA_W   = 64;

	typedef struct packed {
		logic [7:0]  opcode;
		logic [15:0] operand;
		logic [15:0] prog_counter;
		logic [15:0] stack_ptr;
		logic [15:0] hl_pair;
		logic [7:0]  b_count;
		logic        flag_zero;
		logic        flag_carry;
		logic        flag_parity;
		logic        flag_sign;
		logic [15:0] popped_word;
	} in_item_t;

	typedef struct packed {
		logic [15:0] next_pc;
		logic [15:0] next_sp;
		logic [7:0]  next_b;
		logic        push_valid;
		logic [15:0] push_word;
		logic        pop_used;
		timing_t     timing_code;
	} res_item_t;

	function automatic logic cond_holds(input logic [7:0] op, input logic z,
		input logic c, input logic pv, input logic s);
		logic r;
		unique case (cond_t'(op[5:3]))
			COND_NZ: r = ~z;
			COND_Z:  r = z;
			COND_NC: r = ~c;
			COND_C:  r = c;
			COND_PO: r = ~pv;
			COND_PE: r = pv;
			COND_P:  r = ~s;
			COND_M:  r = s;
			default: r = s;
		endcase
		return r;
	endfunction

	// pc plus sign-extended displacement, wrapping
	function automatic logic [15:0] rel_target(input logic [15:0] pc,
		input logic [7:0] disp);
		return pc + {{8{disp[7]}}, disp};
	endfunction

endpackage

`default_nettype wire

// ===== rtl/bjc_exec.sv =====
// ----------------------------------------------------------------------------
// bjc_exec: execute logic of the branch/jump/call unit
// Decodes one instruction and forms the next PC, SP, B and push/pop info.
// ----------------------------------------------------------------------------
`default_nettype none

module bjc_exec (
	input  wire bjc_pkg::kind_t    kind,
	input  wire bjc_pkg::in_item_t item,
	output bjc_pkg::res_item_t     res
);

	logic [15:0] rel_pc;
	logic [7:0]  b_dec;
	logic        cc_ok;
	logic        jr_taken;

	assign rel_pc = bjc_pkg::rel_target(item.prog_counter, item.operand[7:0]);
	assign b_dec  = item.b_count - 8'd1;
	assign cc_ok  = bjc_pkg::cond_holds(item.opcode, item.flag_zero, item.flag_carry,
		item.flag_parity, item.flag_sign);

	always_comb begin
		unique case (kind)
			bjc_pkg::KIND_JRNZ: jr_taken = ~item.flag_zero;
			bjc_pkg::KIND_JRZ:  jr_taken = item.flag_zero;
			bjc_pkg::KIND_JRNC: jr_taken = ~item.flag_carry;
			bjc_pkg::KIND_JRC:  jr_taken = item.flag_carry;
			default:            jr_taken = 1'b0;
		endcase
	end

	always_comb begin
		res.next_pc     = item.prog_counter;
		res.next_sp     = item.stack_ptr;
		res.next_b      = item.b_count;
		res.push_valid  = 1'b0;
		res.push_word   = 16'h0000;
		res.pop_used    = 1'b0;
		res.timing_code = bjc_pkg::TIM_DEFAULT;
		unique case (kind)
			bjc_pkg::KIND_DJNZ: begin
				res.next_b = b_dec;
				if (b_dec == 8'd0) begin
					res.timing_code = bjc_pkg::TIM_DJNZ_FALL;
				end else begin
					res.next_pc = rel_pc;
				end
			end
			bjc_pkg::KIND_JR: begin
				res.next_pc = rel_pc;
			end
			bjc_pkg::KIND_JRNZ, bjc_pkg::KIND_JRZ,
			bjc_pkg::KIND_JRNC, bjc_pkg::KIND_JRC: begin
				if (jr_taken) begin
					res.next_pc = rel_pc;
				end else begin
					res.timing_code = bjc_pkg::TIM_JRCC_SKIP;
				end
			end
			bjc_pkg::KIND_JP: begin
				res.next_pc = item.operand;
			end
			bjc_pkg::KIND_JPCC: begin
				if (cc_ok) begin
					res.next_pc = item.operand;
				end
			end
			bjc_pkg::KIND_JPHL: begin
				res.next_pc = item.hl_pair;
			end
			bjc_pkg::KIND_CALL, bjc_pkg::KIND_CALLCC: begin
				if (kind == bjc_pkg::KIND_CALL || cc_ok) begin
					res.push_valid = 1'b1;
					res.push_word  = item.prog_counter;
					res.next_sp    = item.stack_ptr - 16'd2;
					res.next_pc    = item.operand;
				end else begin
					res.timing_code = bjc_pkg::TIM_CALLCC_SKIP;
				end
			end
			bjc_pkg::KIND_RET, bjc_pkg::KIND_RETCC: begin
				if (kind == bjc_pkg::KIND_RET || cc_ok) begin
					res.pop_used = 1'b1;
					res.next_pc  = item.popped_word;
					res.next_sp  = item.stack_ptr + 16'd2;
				end else begin
					res.timing_code = bjc_pkg::TIM_RETCC_SKIP;
				end
			end
			bjc_pkg::KIND_RST: begin
				res.push_valid = 1'b1;
				res.push_word  = item.prog_counter + 16'd1;
				res.next_sp    = item.stack_ptr - 16'd2;
				res.next_pc    = {8'h00, item.opcode & bjc_pkg::RST_VEC_MASK};
			end
			default: begin
				// NOP and the unused kind code: state passes through
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/cpu_branch_jump_call_unit.sv =====
// ----------------------------------------------------------------------------
// cpu_branch_jump_call_unit: branch/jump/call/return execute stage
// Input register, decode/execute logic, result register on stream ports.
// ----------------------------------------------------------------------------
// Path: the input register takes each accepted item and the result register takes
// the executed result from it; a stall on tready can hold the item between them.
// Throughput: one item per cycle while the result side keeps taking items; set by
// the single execute pass between regs. The input register keeps taking items
// while a result waits on tready, until both stages are full.
// Reset: arst_n low clears both stage valid flags; payload regs are not reset.
`default_nettype none

module cpu_branch_jump_call_unit (
	input  wire                            clk,
	input  wire                            arst_n,
	// input item stream
	input  wire                            s_axis_tvalid,
	output logic                           s_axis_tready,
	// tdata, low bit up: opcode[7:0], operand[23:8], prog_counter[39:24],
	// stack_ptr[55:40], hl_pair[71:56], b_count[79:72], flag_zero[80],
	// flag_carry[81], flag_parity[82], flag_sign[83], popped_word[99:84],
	// zero pad[103:100]
	input  wire [bjc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// tuser: kind[3:0]
	input  wire [3:0]                      s_axis_tuser,
	// result item stream
	output logic                           m_axis_tvalid,
	input  wire                            m_axis_tready,
	// tdata, low bit up: next_pc[15:0], next_sp[31:16], next_b[39:32],
	// push_valid[40], push_word[56:41], pop_used[57], timing_code[60:58],
	// zero pad[63:61]
	output logic [bjc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

	// stage 1: registered input item
	logic                v_s1;
	bjc_pkg::kind_t      kind_s1;
	bjc_pkg::in_item_t   item_s1;
	// stage 2: registered result item
	logic                v_s2;
	bjc_pkg::res_item_t  res_s2;

	bjc_pkg::in_item_t   item_in;
	bjc_pkg::res_item_t  res_d;
	logic                adv_s1;
	logic                load_s1;

	// unpack input tdata
	always_comb begin
		item_in.opcode       = s_axis_tdata[7:0];
		item_in.operand      = s_axis_tdata[23:8];
		item_in.prog_counter = s_axis_tdata[39:24];
		item_in.stack_ptr    = s_axis_tdata[55:40];
		item_in.hl_pair      = s_axis_tdata[71:56];
		item_in.b_count      = s_axis_tdata[79:72];
		item_in.flag_zero    = s_axis_tdata[80];
		item_in.flag_carry   = s_axis_tdata[81];
		item_in.flag_parity  = s_axis_tdata[82];
		item_in.flag_sign    = s_axis_tdata[83];
		item_in.popped_word  = s_axis_tdata[99:84];
	end

	// stage 1 moves on when stage 2 is empty or draining this cycle
	assign adv_s1        = v_s1 & (~v_s2 | m_axis_tready);
	assign s_axis_tready = ~v_s1 | adv_s1;
	assign load_s1       = s_axis_tvalid & s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			kind_s1 <= bjc_pkg::kind_t'(s_axis_tuser);
			item_s1 <= item_in;
		end
	end

	bjc_exec u_exec (
		.kind (kind_s1),
		.item (item_s1),
		.res  (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (~v_s2 | m_axis_tready) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_d;
		end
	end

	assign m_axis_tvalid = v_s2;
	assign m_axis_tdata  = {3'b000, res_s2.timing_code, res_s2.pop_used, res_s2.push_word,
		res_s2.push_valid, res_s2.next_b, res_s2.next_sp, res_s2.next_pc};

	// a result never both pushes and pops
	a_push_pop_excl: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> !(res_s2.push_valid && res_s2.pop_used))
		else $error("result both pushes and pops");

	// timing code stays within the defined codes
	a_timing_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (res_s2.timing_code <= bjc_pkg::TIM_CALLCC_SKIP))
		else $error("undefined timing code");

	// a full stage 1 with an empty stage 2 always moves forward
	a_s1_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !v_s2) |=> v_s2)
		else $error("stage 1 item did not advance");

	// no item is taken while both stages are full and stalled
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 && !m_axis_tready) |-> !s_axis_tready)
		else $error("input accepted into full pipeline");

	// no push word without a push
	a_push_word_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !res_s2.push_valid) |-> (res_s2.push_word == 16'h0000))
		else $error("push word set without push");

endmodule

`default_nettype wire

// ===== sim/bjc_checker.sv =====
// ----------------------------------------------------------------------------
// bjc_checker: result checker for the branch/jump/call unit
// Watches both item streams, works out the outcome of every accepted
// instruction and compares each result item with the oldest outcome.
// ----------------------------------------------------------------------------
`default_nettype none

module bjc_checker (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	input  wire         s_tready,
	input  wire [103:0] s_tdata,
	input  wire [3:0]   s_tuser,
	input  wire         m_tvalid,
	input  wire         m_tready,
	input  wire [63:0]  m_tdata,
	output int          mismatches,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	bjc_pkg::res_item_t expected_outcomes[$];

	function automatic logic cond_met(input bjc_pkg::in_item_t ins);
		logic met;
		case (bjc_pkg::cond_t'(ins.opcode[5:3]))
			bjc_pkg::COND_NZ: met = !ins.flag_zero;
			bjc_pkg::COND_Z:  met = ins.flag_zero;
			bjc_pkg::COND_NC: met = !ins.flag_carry;
			bjc_pkg::COND_C:  met = ins.flag_carry;
			bjc_pkg::COND_PO: met = !ins.flag_parity;
			bjc_pkg::COND_PE: met = ins.flag_parity;
			bjc_pkg::COND_P:  met = !ins.flag_sign;
			default:          met = ins.flag_sign;
		endcase
		return met;
	endfunction

	function automatic logic [15:0] rel_jump(input logic [15:0] pc, input logic [7:0] disp);
		logic [15:0] ext;
		ext = {{8{disp[7]}}, disp};
		return pc + ext;
	endfunction

	function automatic bjc_pkg::res_item_t branch_outcome(input logic [3:0] kind,
		input bjc_pkg::in_item_t ins);
		bjc_pkg::res_item_t r;
		logic taken;
		r.next_pc     = ins.prog_counter;
		r.next_sp     = ins.stack_ptr;
		r.next_b      = ins.b_count;
		r.push_valid  = 1'b0;
		r.push_word   = 16'h0000;
		r.pop_used    = 1'b0;
		r.timing_code = bjc_pkg::TIM_DEFAULT;
		case (bjc_pkg::kind_t'(kind))
			bjc_pkg::KIND_DJNZ: begin
				r.next_b = ins.b_count - 8'd1;
				if (r.next_b == 8'd0)
					r.timing_code = bjc_pkg::TIM_DJNZ_FALL;
				else
					r.next_pc = rel_jump(ins.prog_counter, ins.operand[7:0]);
			end
			bjc_pkg::KIND_JR: r.next_pc = rel_jump(ins.prog_counter, ins.operand[7:0]);
			bjc_pkg::KIND_JRNZ, bjc_pkg::KIND_JRZ, bjc_pkg::KIND_JRNC,
			bjc_pkg::KIND_JRC: begin
				case (bjc_pkg::kind_t'(kind))
					bjc_pkg::KIND_JRNZ: taken = !ins.flag_zero;
					bjc_pkg::KIND_JRZ:  taken = ins.flag_zero;
					bjc_pkg::KIND_JRNC: taken = !ins.flag_carry;
					default:            taken = ins.flag_carry;
				endcase
				if (taken)
					r.next_pc = rel_jump(ins.prog_counter, ins.operand[7:0]);
				else
					r.timing_code = bjc_pkg::TIM_JRCC_SKIP;
			end
			bjc_pkg::KIND_JP: r.next_pc = ins.operand;
			bjc_pkg::KIND_JPCC: if (cond_met(ins)) r.next_pc = ins.operand;
			bjc_pkg::KIND_JPHL: r.next_pc = ins.hl_pair;
			bjc_pkg::KIND_CALL, bjc_pkg::KIND_CALLCC: begin
				if (kind == bjc_pkg::KIND_CALL || cond_met(ins)) begin
					r.push_valid = 1'b1;
					r.push_word  = ins.prog_counter;
					r.next_sp    = ins.stack_ptr - 16'd2;
					r.next_pc    = ins.operand;
				end else begin
					r.timing_code = bjc_pkg::TIM_CALLCC_SKIP;
				end
			end
			bjc_pkg::KIND_RET, bjc_pkg::KIND_RETCC: begin
				if (kind == bjc_pkg::KIND_RET || cond_met(ins)) begin
					r.pop_used = 1'b1;
					r.next_pc  = ins.popped_word;
					r.next_sp  = ins.stack_ptr + 16'd2;
				end else begin
					r.timing_code = bjc_pkg::TIM_RETCC_SKIP;
				end
			end
			bjc_pkg::KIND_RST: begin
				r.push_valid = 1'b1;
				r.push_word  = ins.prog_counter + 16'd1;
				r.next_sp    = ins.stack_ptr - 16'd2;
				r.next_pc    = {8'h00, ins.opcode & bjc_pkg::RST_VEC_MASK};
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		bjc_pkg::res_item_t want;
		bjc_pkg::res_item_t got;
		bjc_pkg::in_item_t  ins;
		if (!arst_n) begin
			expected_outcomes.delete();
			mismatches = 0;
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.next_pc     = m_tdata[15:0];
				got.next_sp     = m_tdata[31:16];
				got.next_b      = m_tdata[39:32];
				got.push_valid  = m_tdata[40];
				got.push_word   = m_tdata[56:41];
				got.pop_used    = m_tdata[57];
				got.timing_code = bjc_pkg::timing_t'(m_tdata[60:58]);
				if (expected_outcomes.size() == 0) begin
					$error("result item with no instruction pending: next_pc %h",
						got.next_pc);
					mismatches++;
				end else begin
					want = expected_outcomes.pop_front();
					check_field("next_pc", want.next_pc, got.next_pc);
					check_field("next_sp", want.next_sp, got.next_sp);
					check_field("next_b", want.next_b, got.next_b);
					check_field("push_valid", want.push_valid, got.push_valid);
					check_field("push_word", want.push_word, got.push_word);
					check_field("pop_used", want.pop_used, got.pop_used);
					check_field("timing_code", want.timing_code, got.timing_code);
				end
			end
			if (s_tvalid && s_tready) begin
				ins.opcode       = s_tdata[7:0];
				ins.operand      = s_tdata[23:8];
				ins.prog_counter = s_tdata[39:24];
				ins.stack_ptr    = s_tdata[55:40];
				ins.hl_pair      = s_tdata[71:56];
				ins.b_count      = s_tdata[79:72];
				ins.flag_zero    = s_tdata[80];
				ins.flag_carry   = s_tdata[81];
				ins.flag_parity  = s_tdata[82];
				ins.flag_sign    = s_tdata[83];
				ins.popped_word  = s_tdata[99:84];
				expected_outcomes.push_back(branch_outcome(s_tuser, ins));
			end
			pending <= expected_outcomes.size();
		end
	end

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench top of the branch/jump/call unit
// Drives directed then random instruction items with random gaps and
// back-pressure; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// kind code left unused by the decoder; must behave as a NOP
	localparam logic [3:0] KIND_UNUSED = 4'hF;
	localparam int RANDOM_ITEMS = 1150;
	// upper bound on the whole run, with plenty of room
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 60;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [103:0] s_axis_tdata;   // opcode, operand, pc, sp, hl, b, z, c, pv, s, popped
	logic [3:0]   s_axis_tuser;   // kind
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [63:0]  m_axis_tdata;   // next_pc, next_sp, next_b, push_v, push_w, pop, timing

	int mismatches;
	int pending;
	int cycles = 0;

	// pacing controls of the sender and the receiver
	bit sender_calm = 1'b0;
	bit recv_calm   = 1'b0;
	bit hold_req    = 1'b0;

	cpu_branch_jump_call_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	bjc_checker bjc_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_axis_tvalid),
		.s_tready   (s_axis_tready),
		.s_tdata    (s_axis_tdata),
		.s_tuser    (s_axis_tuser),
		.m_tvalid   (m_axis_tvalid),
		.m_tready   (m_axis_tready),
		.m_tdata    (m_axis_tdata),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Offer one item and hold it until the block takes it. A zero gap keeps
	// tvalid high straight into the next item.
	task automatic send_item(input logic [3:0] kind, input bjc_pkg::in_item_t it);
		int gap;
		gap = sender_calm ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= {4'h0, it.popped_word, it.flag_sign, it.flag_parity,
			it.flag_carry, it.flag_zero, it.b_count, it.hl_pair, it.stack_ptr,
			it.prog_counter, it.operand, it.opcode};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	// flags nibble is {sign, parity, carry, zero}
	task automatic send_directed(input logic [3:0] kind, input logic [7:0] op,
		input logic [15:0] opnd, input logic [15:0] pc, input logic [15:0] sp,
		input logic [15:0] hl, input logic [7:0] b, input logic [3:0] flags,
		input logic [15:0] popped);
		bjc_pkg::in_item_t it;
		it.opcode       = op;
		it.operand      = opnd;
		it.prog_counter = pc;
		it.stack_ptr    = sp;
		it.hl_pair      = hl;
		it.b_count      = b;
		{it.flag_sign, it.flag_parity, it.flag_carry, it.flag_zero} = flags;
		it.popped_word  = popped;
		send_item(kind, it);
	endtask

	function automatic bjc_pkg::in_item_t random_fields();
		bjc_pkg::in_item_t it;
		it.opcode       = 8'($urandom);
		it.operand      = 16'($urandom);
		it.prog_counter = 16'($urandom);
		it.hl_pair      = 16'($urandom);
		it.popped_word  = 16'($urandom);
		{it.flag_sign, it.flag_parity, it.flag_carry, it.flag_zero} = 4'($urandom);
		// a loop counter of one makes DJNZ fall through
		it.b_count = ($urandom_range(0, 7) == 0) ? 8'd1 : 8'($urandom);
		// stack pointer near the wrap points now and then
		if ($urandom_range(0, 9) == 0) begin
			case ($urandom_range(0, 3))
				0:       it.stack_ptr = 16'h0000;
				1:       it.stack_ptr = 16'h0001;
				2:       it.stack_ptr = 16'hFFFE;
				default: it.stack_ptr = 16'hFFFF;
			endcase
		end else begin
			it.stack_ptr = 16'($urandom);
		end
		return it;
	endfunction

	// result side: random stalls per item, one long hold on request
	initial begin
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			stall = recv_calm ? 0 : $urandom_range(0, 9);
			if (stall != 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
		end
	end

	// stimulus and verdict
	initial begin
		bjc_pkg::in_item_t it;
		logic [3:0]        kind;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= bjc_pkg::KIND_NOP;
		m_axis_tready <= 1'b0;
		arst_n        <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: every kind, field extremes, wrap and sign corners
		send_directed(bjc_pkg::KIND_NOP, 8'h00, 16'hFFFF, 16'h1234, 16'hFFFE, 16'hABCD,
			8'h55, 4'hF, 16'h5A5A);
		send_directed(KIND_UNUSED, 8'hFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 8'hFF,
			4'h0, 16'hFFFF);
		// DJNZ: reaches zero, wraps from zero, taken across the top
		send_directed(bjc_pkg::KIND_DJNZ, 8'h10, 16'h0005, 16'h4000, 16'h8000, 16'h0000,
			8'h01, 4'h0, 16'h0000);
		send_directed(bjc_pkg::KIND_DJNZ, 8'h10, 16'h0080, 16'h0000, 16'h8000, 16'h0000,
			8'h00, 4'h0, 16'h0000);
		send_directed(bjc_pkg::KIND_DJNZ, 8'h10, 16'hFF7F, 16'hFFF0, 16'h8000, 16'h0000,
			8'h02, 4'h0, 16'h0000);
		send_directed(bjc_pkg::KIND_JR, 8'h18, 16'h00FE, 16'h0001, 16'h1000, 16'h0000,
			8'h10, 4'h0, 16'h0000);
		// JR cc, taken and not
		send_directed(bjc_pkg::KIND_JRNZ, 8'h20, 16'h0010, 16'h2000, 16'h1000, 16'h0000,
			8'h10, 4'h0, 16'h0000);
		send_directed(bjc_pkg::KIND_JRNZ, 8'h20, 16'h0010, 16'h2000, 16'h1000, 16'h0000,
			8'h10, 4'h1, 16'h0000);
		send_directed(bjc_pkg::KIND_JRZ, 8'h28, 16'h00F0, 16'h2000, 16'h1000, 16'h0000,
			8'h10, 4'h1, 16'h0000);
		send_directed(bjc_pkg::KIND_JRNC, 8'h30, 16'h007F, 16'hFFFF, 16'h1000, 16'h0000,
			8'h10, 4'h0, 16'h0000);
		send_directed(bjc_pkg::KIND_JRNC, 8'h30, 16'h007F, 16'hFFFF, 16'h1000, 16'h0000,
			8'h10, 4'h2, 16'h0000);
		// JR C with a negative displacement must go backward
		send_directed(bjc_pkg::KIND_JRC, 8'h38, 16'h0090, 16'h0100, 16'h1000, 16'h0000,
			8'h10, 4'h2, 16'h0000);
		send_directed(bjc_pkg::KIND_JRC, 8'h38, 16'h0090, 16'h0100, 16'h1000, 16'h0000,
			8'h10, 4'h0, 16'h0000);
		send_directed(bjc_pkg::KIND_JP, 8'hC3, 16'hFFFF, 16'h0000, 16'h1000, 16'h0000,
			8'h10, 4'h0, 16'h0000);
		// JP cc not taken leaves pc alone with default timing
		send_directed(bjc_pkg::KIND_JPCC, 8'hC2, 16'h8000, 16'h0300, 16'h1000, 16'h0000,
			8'h10, 4'h1, 16'h0000);
		send_directed(bjc_pkg::KIND_JPCC, 8'hFA, 16'h8000, 16'h0300, 16'h1000, 16'h0000,
			8'h10, 4'h8, 16'h0000);
		send_directed(bjc_pkg::KIND_JPCC, 8'hE2, 16'h0000, 16'h0300, 16'h1000, 16'h0000,
			8'h10, 4'h0, 16'h0000);
		send_directed(bjc_pkg::KIND_JPHL, 8'hE9, 16'h0000, 16'h0300, 16'h1000, 16'hFFFF,
			8'h10, 4'h0, 16'h0000);
		// push and pop across the stack wrap
		send_directed(bjc_pkg::KIND_CALL, 8'hCD, 16'h1234, 16'hFFFF, 16'h0000, 16'h0000,
			8'h10, 4'h0, 16'h0000);
		send_directed(bjc_pkg::KIND_CALLCC, 8'hDC, 16'h1234, 16'h0400, 16'h2000, 16'h0000,
			8'h10, 4'h0, 16'h0000);
		send_directed(bjc_pkg::KIND_CALLCC, 8'hEC, 16'h4321, 16'h0400, 16'h0001, 16'h0000,
			8'h10, 4'h4, 16'h0000);
		send_directed(bjc_pkg::KIND_RET, 8'hC9, 16'h0000, 16'h0400, 16'hFFFF, 16'h0000,
			8'h10, 4'h0, 16'hFFFF);
		send_directed(bjc_pkg::KIND_RETCC, 8'hC8, 16'h0000, 16'h0400, 16'h3000, 16'h0000,
			8'h10, 4'h0, 16'hBEEF);
		send_directed(bjc_pkg::KIND_RETCC, 8'hF0, 16'h0000, 16'h0400, 16'hFFFE, 16'h0000,
			8'h10, 4'h0, 16'hBEEF);
		// RST: return address wraps, vector from opcode bits 5:3
		send_directed(bjc_pkg::KIND_RST, 8'hFF, 16'h0000, 16'hFFFF, 16'h5000, 16'h0000,
			8'h10, 4'h0, 16'h0000);
		send_directed(bjc_pkg::KIND_RST, 8'h00, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000,
			8'h10, 4'hF, 16'h0000);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// a stretch with no idling on either side, then a burst into a long
			// receiver hold so the block backs up into its input
			recv_calm   = (n >= 300 && n < 400);
			sender_calm = (n >= 300 && n < 400) || (n >= 500 && n < 540);
			if (n == 500)
				hold_req = 1'b1;
			// let the pipe run dry once before carrying on
			if (n == 800) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
			it   = random_fields();
			kind = ($urandom_range(0, 99) < 4) ? KIND_UNUSED : 4'($urandom_range(0, 14));
			send_item(kind, it);
		end

		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		// two-stage pipe; the wait below catches any stray result
		repeat (10) @(posedge clk);
		@(negedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

`default_nettype wire
